// ===== rtl/zca_pkg.sv =====
// Shared types and constants for the zone color averager.
// Holds the input and result transaction structs, the FIFO status bundle
// and the back-end state encoding. Depends on nothing.
package zca_pkg;

  // Widest zone count that the register may select
  localparam int unsigned ZoneFieldMax = 256;

  // Quotient bits produced per channel, one bit per divider step
  localparam int unsigned QuoSteps = 8;
  localparam int unsigned StepW    = 3;

  // Reset value of the zone count register
  localparam logic [8:0] ZoneCountReset = 9'd228;

  // One input transaction
  typedef struct packed {
    logic [23:0] pixel_color;
    logic        has_sample;
    logic        zone_end;
  } zca_in_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] zone_index;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic       updated;
    logic       sample_overflow;
  } zca_out_t;

  // Status of the job queue as seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } zca_fifo_stat_t;

  // Back-end divider sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } zca_state_t;

endpackage

// ===== rtl/zca_front.sv =====
// Front end of the zone color averager: accepts pixel transactions, keeps the
// per-zone sums, sample count and zone index, and pushes one job per zone end.
// Depends on zca_pkg.
module zca_front #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned MAX_ZONES   = 256,
  parameter int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int unsigned SUM_W       = CNT_W + 8,
  parameter int unsigned JOB_W       = 8 + 3 * SUM_W + CNT_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  zca_pkg::zca_in_t        in_data,
  output logic                    in_stall,
  input  logic                    cfg_wr_en,
  input  logic [8:0]              cfg_wr_data,
  input  zca_pkg::zca_fifo_stat_t fifo_stat,
  output logic                    push,
  output logic [JOB_W-1:0]        push_data
);
  import zca_pkg::*;

  localparam int unsigned ZoneCapInt = (MAX_ZONES < ZoneFieldMax) ? MAX_ZONES : ZoneFieldMax;
  localparam logic [8:0]       ZoneCap  = 9'(ZoneCapInt);
  localparam logic [CNT_W-1:0] SampMax  = CNT_W'(MAX_SAMPLES);

  logic [SUM_W-1:0] red_sum, green_sum, blue_sum;
  logic [SUM_W-1:0] red_sum_next, green_sum_next, blue_sum_next;
  logic [CNT_W-1:0] sample_total, sample_total_next;
  logic             overflow_seen, overflow_seen_next;
  logic [7:0]       current_zone, current_zone_next;
  logic [8:0]       zone_count;
  logic [8:0]       zone_limit;
  logic [8:0]       zone_inc;
  logic             accept;
  logic             take;
  logic [SUM_W-1:0] red_add, green_add, blue_add;
  logic [CNT_W-1:0] total_add;
  logic             ovf_add;

  // A job is pushed on every zone end, so hold off while the queue is full.
  assign in_stall = fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign take     = accept && in_data.has_sample && (sample_total < SampMax);

  // Sums including the current transaction's sample.
  always_comb begin
    red_add   = red_sum;
    green_add = green_sum;
    blue_add  = blue_sum;
    total_add = sample_total;
    if (take) begin
      red_add   = red_sum + SUM_W'(in_data.pixel_color[23:16]);
      green_add = green_sum + SUM_W'(in_data.pixel_color[15:8]);
      blue_add  = blue_sum + SUM_W'(in_data.pixel_color[7:0]);
      total_add = sample_total + CNT_W'(1);
    end
    ovf_add = overflow_seen || (accept && in_data.has_sample && !(sample_total < SampMax));
  end

  // A zone end hands the completed zone to the back end.
  assign push      = accept && in_data.zone_end;
  assign push_data = {current_zone, red_add, green_add, blue_add, total_add, ovf_add};

  // Effective zone count: zero or above the field maximum selects the maximum, and the result is capped at MAX_ZONES.
  always_comb begin
    if (zone_count == 9'd0 || zone_count > 9'(ZoneFieldMax)) begin
      zone_limit = 9'(ZoneFieldMax);
    end else begin
      zone_limit = zone_count;
    end
    if (zone_limit > ZoneCap) begin
      zone_limit = ZoneCap;
    end
    zone_inc = {1'b0, current_zone} + 9'd1;
  end

  // Next values of the accumulators and the zone index.
  always_comb begin
    red_sum_next       = red_sum;
    green_sum_next     = green_sum;
    blue_sum_next      = blue_sum;
    sample_total_next  = sample_total;
    overflow_seen_next = overflow_seen;
    current_zone_next  = current_zone;
    if (push) begin
      red_sum_next       = '0;
      green_sum_next     = '0;
      blue_sum_next      = '0;
      sample_total_next  = '0;
      overflow_seen_next = 1'b0;
      current_zone_next  = (zone_inc >= zone_limit) ? 8'd0 : zone_inc[7:0];
    end else if (accept) begin
      red_sum_next       = red_add;
      green_sum_next     = green_add;
      blue_sum_next      = blue_add;
      sample_total_next  = total_add;
      overflow_seen_next = ovf_add;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_sum       <= '0;
      green_sum     <= '0;
      blue_sum      <= '0;
      sample_total  <= '0;
      overflow_seen <= 1'b0;
      current_zone  <= 8'd0;
      zone_count    <= ZoneCountReset;
    end else begin
      red_sum       <= red_sum_next;
      green_sum     <= green_sum_next;
      blue_sum      <= blue_sum_next;
      sample_total  <= sample_total_next;
      overflow_seen <= overflow_seen_next;
      current_zone  <= current_zone_next;
      if (cfg_wr_en) begin
        zone_count <= cfg_wr_data;
      end
    end
  end

  // The sample count never passes its saturation point.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    sample_total <= SampMax)
    else $error("sample count above saturation limit");

  // Closing a zone clears the accumulators.
  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    push |=> (sample_total == '0 && !overflow_seen && red_sum == '0))
    else $error("accumulators not cleared after zone end");

  // The zone index either advances by one or wraps to zero.
  a_zone_step: assert property (@(posedge clk) disable iff (rst)
    push |=> (current_zone == 8'd0 || current_zone == ($past(current_zone) + 8'd1)))
    else $error("zone index moved unexpectedly");

endmodule

// ===== rtl/zca_fifo.sv =====
// Small job queue between the front and back ends of the zone color averager.
// Register array with read and write pointers and an occupancy count.
// Depends on zca_pkg.
module zca_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        pop_data,
  output zca_pkg::zca_fifo_stat_t stat
);
  import zca_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  assign stat.full  = (count == CntFull);
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  // The writer never pushes into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("push into full queue");

  // The reader never pops an empty queue.
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  // Occupancy rises by one on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == ($past(count) + CntW'(1)))
    else $error("queue count did not advance on push");

endmodule

// ===== rtl/zca_back.sv =====
// Back end of the zone color averager: pops zone jobs and divides the three
// channel sums by the sample count one quotient bit per cycle, then registers
// the result transaction. Depends on zca_pkg.
module zca_back #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int unsigned SUM_W       = CNT_W + 8,
  parameter int unsigned JOB_W       = 8 + 3 * SUM_W + CNT_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  zca_pkg::zca_fifo_stat_t fifo_stat,
  input  logic [JOB_W-1:0]        pop_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output zca_pkg::zca_out_t       out_data
);
  import zca_pkg::*;

  zca_state_t       state, state_next;
  logic [7:0]       zone_idx;
  logic             job_ovf;
  logic             cnt_zero;
  logic [SUM_W-1:0] rem_red, rem_green, rem_blue;
  logic [SUM_W-1:0] div_val;
  logic [7:0]       quo_red, quo_green, quo_blue;
  logic [StepW-1:0] step;
  logic             run;
  logic             emit;
  logic             out_free;

  // Job fields.
  logic [7:0]       job_zone;
  logic [SUM_W-1:0] job_red, job_green, job_blue;
  logic [CNT_W-1:0] job_cnt;
  logic             job_flag;

  assign {job_zone, job_red, job_green, job_blue, job_cnt, job_flag} = pop_data;

  // Per-channel trial subtraction.
  logic ge_red, ge_green, ge_blue;
  assign ge_red   = (rem_red >= div_val);
  assign ge_green = (rem_green >= div_val);
  assign ge_blue  = (rem_blue >= div_val);

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!fifo_stat.empty) state_next = BK_DIV;
      BK_DIV:  if (step == '0) state_next = BK_DONE;
      BK_DONE: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop  = 1'b0;
    run  = 1'b0;
    emit = 1'b0;
    unique case (state)
      BK_IDLE: pop  = !fifo_stat.empty;
      BK_DIV:  run  = 1'b1;
      BK_DONE: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath: divisor starts at count times 128 and halves each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (pop) begin
      step <= StepW'(QuoSteps - 1);
    end else if (run && step != '0) begin
      step <= step - StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      zone_idx  <= job_zone;
      job_ovf   <= job_flag;
      cnt_zero  <= (job_cnt == '0);
      rem_red   <= job_red;
      rem_green <= job_green;
      rem_blue  <= job_blue;
      div_val   <= SUM_W'({job_cnt, 7'b0});
      quo_red   <= '0;
      quo_green <= '0;
      quo_blue  <= '0;
    end else if (run) begin
      rem_red   <= ge_red ? rem_red - div_val : rem_red;
      rem_green <= ge_green ? rem_green - div_val : rem_green;
      rem_blue  <= ge_blue ? rem_blue - div_val : rem_blue;
      quo_red   <= {quo_red[6:0], ge_red};
      quo_green <= {quo_green[6:0], ge_green};
      quo_blue  <= {quo_blue[6:0], ge_blue};
      div_val   <= div_val >> 1;
    end
  end

  // Output register for the result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.zone_index      <= zone_idx;
      out_data.avg_red         <= cnt_zero ? 8'd0 : quo_red;
      out_data.avg_green       <= cnt_zero ? 8'd0 : quo_green;
      out_data.avg_blue        <= cnt_zero ? 8'd0 : quo_blue;
      out_data.updated         <= !cnt_zero;
      out_data.sample_overflow <= job_ovf;
    end
  end

  // Partial remainder stays below twice the current divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV && !cnt_zero) |-> (rem_red < (div_val << 1)))
    else $error("divider remainder out of range");

  // All quotient bits are done before the result is released.
  a_done_step: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE) |-> (step == '0))
    else $error("result released before divider finished");

  // A released result shows up as a valid transaction.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result lost after release");

  // An empty zone reports zero averages.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.updated) |->
      (out_data.avg_red == 8'd0 && out_data.avg_green == 8'd0 && out_data.avg_blue == 8'd0))
    else $error("empty zone reported nonzero color");

endmodule

// ===== rtl/zone_color_averager_top.sv =====
// Zone color averager top level. A zone-end transaction passes through the queue
// write at the accepting edge, then the job pop, eight divider steps and the
// output register. Pixel transactions are taken one per cycle while the job
// queue is not full; zone results leave one at a time from the shared bit-serial
// divider, which pops no new job before the last result is registered; a 4-deep
// job queue absorbs closely spaced zones.
// Synchronous reset clears all sums, the zone index and sets zone count 228.
module zone_color_averager_top #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned MAX_ZONES   = 256,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  zca_pkg::zca_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output zca_pkg::zca_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data
);
  import zca_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = CntW + 8;
  localparam int unsigned JobW = 8 + 3 * SumW + CntW + 1;

  zca_fifo_stat_t  fifo_stat;
  logic            push;
  logic [JobW-1:0] push_data;
  logic            pop;
  logic [JobW-1:0] pop_data;

  // Accumulation front end.
  zca_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_ZONES   (MAX_ZONES),
    .CNT_W       (CntW),
    .SUM_W       (SumW),
    .JOB_W       (JobW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fifo_stat   (fifo_stat),
    .push        (push),
    .push_data   (push_data)
  );

  // Job queue between the two halves.
  zca_fifo #(
    .WIDTH (JobW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  // Division back end.
  zca_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CntW),
    .SUM_W       (SumW),
    .JOB_W       (JobW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the zone color averager top level.
// Drives pixel transactions through a queue-fed driver, predicts each zone average
// in the testbench, and checks every result transaction. Depends on zca_pkg.
module tb;
  import zca_pkg::*;

  localparam int unsigned MaxSamples  = 4096;
  localparam int unsigned MaxZones    = 256;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned IdleLimit   = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  zca_in_t    in_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  zca_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;

  // Pixel transactions waiting to be driven, and those not yet accepted.
  zca_in_t     pending_pixels[$];
  int unsigned in_flight = 0;

  // Zone averages that the block is expected to report, oldest first.
  zca_out_t    zone_results[$];

  // Idle rates of the sender and of the receiver, in percent.
  int unsigned send_idle_pct = 30;
  int unsigned recv_stall_pct = 71;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Shadow of the zone count register and of the accumulator state.
  logic [8:0]  zone_cfg = ZoneCountReset;
  int unsigned red_acc = 0;
  int unsigned green_acc = 0;
  int unsigned blue_acc = 0;
  int unsigned pix_total = 0;
  int unsigned zone_now = 0;
  logic        clipped = 1'b0;

  zone_color_averager_top #(
    .MAX_SAMPLES(MaxSamples),
    .MAX_ZONES(MaxZones)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_data(in_data),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Accumulate one accepted transaction and, at a zone end, compute its average.
  function automatic void track_zone_average(input zca_in_t t);
    zca_out_t    r;
    int unsigned lim;
    int unsigned nxt;
    if (t.has_sample) begin
      if (pix_total < MaxSamples) begin
        red_acc   += t.pixel_color[23:16];
        green_acc += t.pixel_color[15:8];
        blue_acc  += t.pixel_color[7:0];
        pix_total++;
      end else begin
        clipped = 1'b1;
      end
    end
    if (t.zone_end) begin
      r.zone_index = 8'(zone_now);
      if (pix_total != 0) begin
        r.avg_red   = 8'(red_acc / pix_total);
        r.avg_green = 8'(green_acc / pix_total);
        r.avg_blue  = 8'(blue_acc / pix_total);
        r.updated   = 1'b1;
      end else begin
        r.avg_red   = '0;
        r.avg_green = '0;
        r.avg_blue  = '0;
        r.updated   = 1'b0;
      end
      r.sample_overflow = clipped;
      zone_results.push_back(r);
      red_acc   = 0;
      green_acc = 0;
      blue_acc  = 0;
      pix_total = 0;
      clipped   = 1'b0;
      // A count of zero or above the field maximum selects the widest frame.
      lim = (zone_cfg == 0 || zone_cfg > ZoneFieldMax) ? ZoneFieldMax : zone_cfg;
      if (lim > MaxZones) begin
        lim = MaxZones;
      end
      nxt = zone_now + 1;
      zone_now = (nxt >= lim) ? 0 : nxt;
    end
  endfunction

  // Driver: hold a stalled transaction, otherwise load the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_zone_average(in_data);
        in_flight--;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and a field-by-field check of each result.
  always @(posedge clk) begin
    zca_out_t want;
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (zone_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected zone result: idx %0d rgb %h %h %h upd %b ovf %b",
                   out_data.zone_index, out_data.avg_red, out_data.avg_green,
                   out_data.avg_blue, out_data.updated, out_data.sample_overflow);
        end
      end else begin
        want = zone_results.pop_front();
        if (out_data.zone_index !== want.zone_index || out_data.avg_red !== want.avg_red ||
            out_data.avg_green !== want.avg_green || out_data.avg_blue !== want.avg_blue ||
            out_data.updated !== want.updated ||
            out_data.sample_overflow !== want.sample_overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Zone result differs: want idx %0d rgb %h %h %h upd %b ovf %b",
                     want.zone_index, want.avg_red, want.avg_green, want.avg_blue,
                     want.updated, want.sample_overflow);
            $display("                     got  idx %0d rgb %h %h %h upd %b ovf %b",
                     out_data.zone_index, out_data.avg_red, out_data.avg_green,
                     out_data.avg_blue, out_data.updated, out_data.sample_overflow);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic [23:0] pix, input logic has, input logic last);
    zca_in_t t;
    t.pixel_color = pix;
    t.has_sample  = has;
    t.zone_end    = last;
    pending_pixels.push_back(t);
    in_flight++;
  endtask

  // Mix of full-scale, black, per-channel extremes and fully random pixels.
  function automatic logic [23:0] pick_pixel();
    logic [23:0] p;
    case ($urandom_range(0, 5))
      0: begin
        p = 24'hFFFFFF;
      end
      1: begin
        p = 24'h000000;
      end
      2: begin
        p = 24'($urandom());
        for (int c = 0; c < 3; c++) begin
          if ($urandom_range(0, 1)) begin
            p[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end
        end
      end
      default: begin
        p = 24'($urandom());
      end
    endcase
    return p;
  endfunction

  // Wait until every transaction is accepted and every result has arrived.
  task automatic settle();
    while (in_flight != 0 || zone_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_zone_count(input logic [8:0] value);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    zone_cfg = value;
  endtask

  // Random zones: mostly samples, some empty closes, a little ignored noise.
  task automatic queue_random_zones(input int unsigned count, input int unsigned end_pct);
    int unsigned queued;
    logic        has;
    logic        last;
    queued = 0;
    while (queued < count) begin
      has  = ($urandom_range(0, 99) < 88);
      last = ($urandom_range(0, 99) < end_pct);
      push_item(pick_pixel(), has, last);
      // A transaction with neither a sample nor a zone end does nothing.
      if (has || last) begin
        queued++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed zones at the reset zone count.
    push_item(24'hFFFFFF, 1'b1, 1'b1);  // sample on the closing transaction
    push_item(24'h000000, 1'b0, 1'b1);  // empty zone
    push_item(24'hFFFFFF, 1'b0, 1'b1);  // empty zone, pixel ignored
    push_item(24'hFF0000, 1'b1, 1'b0);
    push_item(24'h00FF00, 1'b1, 1'b0);
    push_item(24'h0000FF, 1'b1, 1'b1);
    push_item(24'h000000, 1'b1, 1'b0);
    push_item(24'hFFFFFF, 1'b1, 1'b1);
    push_item(24'h123456, 1'b1, 1'b0);
    push_item(24'hABCDEF, 1'b0, 1'b0);
    push_item(24'h000001, 1'b1, 1'b1);
    push_item(24'hAAAAAA, 1'b1, 1'b0);
    push_item(24'h555555, 1'b1, 1'b1);
    push_item(24'h000000, 1'b1, 1'b1);  // one black sample still counts as updated

    // A single-zone frame, entered with the index above the new count.
    write_zone_count(9'd1);
    push_item(24'h800080, 1'b1, 1'b1);
    push_item(24'h7F7F7F, 1'b0, 1'b1);
    push_item(24'h010203, 1'b1, 1'b1);
    push_item(24'h404040, 1'b1, 1'b1);

    // Random phases over several zone counts, the extremes among them.
    write_zone_count(9'd256);
    queue_random_zones(250, 60);
    settle();
    send_idle_pct  = 71;
    recv_stall_pct = 30;
    write_zone_count(9'd0);
    queue_random_zones(100, 25);
    write_zone_count(9'd511);
    queue_random_zones(100, 25);
    write_zone_count(9'd257);
    queue_random_zones(100, 25);
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_zone_count(9'd2);
    queue_random_zones(100, 30);
    write_zone_count(9'($urandom_range(0, 511)));
    queue_random_zones(100, 20);
    write_zone_count(9'd3);
    queue_random_zones(50, 40);

    settle();
    mismatches += zone_results.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
